// ===== src/hfla_pkg.sv =====
// Shared types, constants and codes of the handle free-list allocator.
`default_nettype none
package hfla_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int HANDLE_W     = 6;
  localparam int BASE_W       = 32;
  localparam int SLOT_W       = 16;
  localparam int ADDR_W       = 33;
  localparam int PROD_W       = HANDLE_W + SLOT_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [SLOT_W-1:0] SLOT_SIZE_RST = SLOT_W'(64);

  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_ADDRESS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 1'd0,
    CFG_SLOT_SIZE    = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_POP  = 2'd1,
    ST_SCAN = 2'd2,
    ST_SUM  = 2'd3
  } state_t;

  typedef enum logic [2:0] {
    FIN_NONE = 3'd0,
    FIN_IMM  = 3'd1,
    FIN_POP  = 3'd2,
    FIN_SCAN = 3'd3,
    FIN_SUM  = 3'd4
  } fin_t;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  granted;
    logic                 in_use;
    logic [ADDR_W-1:0]    slot_address;
    status_t              status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic scan_next;
    fin_t fin;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/hfla_dp.sv =====
// Datapath of the allocator: free stack memory, counters, address arithmetic, result register.
`default_nettype none
module hfla_dp #(
  parameter int CAPACITY = hfla_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hfla_pkg::in_t                     in_word,
  input  hfla_pkg::cmd_t                    cmd,
  output hfla_pkg::dp_status_t              stat,
  input  logic                              cfg_we,
  input  logic [hfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hfla_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  output hfla_pkg::out_t                    out_word
);
  import hfla_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [HANDLE_W-1:0] mem [CAPACITY];

  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       mark_r, mark_nxt;
  logic [CW-1:0]       count_m1;
  logic [AW-1:0]       scan_idx_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PROD_W-1:0]   prod_r;
  logic [BASE_W-1:0]   base_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [AW-1:0]       rd_addr;
  logic [HANDLE_W-1:0] rd_q;
  logic                rd_fresh_r;
  logic [HANDLE_W-1:0] rd_low_r;
  logic [HANDLE_W-1:0] value;
  logic                mem_we;
  logic                out_valid_r;
  out_t                out_word_r, out_word_nxt;

  assign count_m1   = count_r - CW'(1);
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r >= CAP_C);

  // Entries below the low-water mark were never written; their value is taken as their own index.
  assign value     = rd_fresh_r ? rd_low_r : rd_q;
  assign stat.hit  = (value == handle_r);
  assign stat.last = (CW'(scan_idx_r) == count_m1);

  assign mem_we = cmd.accept && (in_word.kind == KIND_RELEASE) && !stat.full;

  always_comb begin
    if (cmd.accept && (in_word.kind == KIND_ACQUIRE)) begin
      rd_addr = count_m1[AW-1:0];
    end else if (cmd.scan_next) begin
      rd_addr = scan_idx_r + AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= in_word.handle;
    end
    rd_q       <= mem[rd_addr];
    rd_fresh_r <= (CW'(rd_addr) < mark_r);
    rd_low_r   <= HANDLE_W'(rd_addr);
  end

  always_comb begin
    count_nxt = count_r;
    mark_nxt  = mark_r;
    if (cmd.accept) begin
      if ((in_word.kind == KIND_ACQUIRE) && !stat.empty) begin
        count_nxt = count_m1;
        if (count_m1 < mark_r) begin
          mark_nxt = count_m1;
        end
      end else if ((in_word.kind == KIND_RELEASE) && !stat.full) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CAP_C;
      mark_r  <= CAP_C;
    end else begin
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      slot_r <= SLOT_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_ADDRESS: base_r <= cfg_wdata[BASE_W-1:0];
        CFG_SLOT_SIZE:    slot_r <= cfg_wdata[SLOT_W-1:0];
        default:          base_r <= base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      handle_r <= in_word.handle;
      prod_r   <= PROD_W'(in_word.handle) * PROD_W'(slot_r);
    end
    if (cmd.accept) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_next) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
  end

  always_comb begin
    out_word_nxt = '0;
    case (cmd.fin)
      FIN_IMM: begin
        out_word_nxt.in_use = (in_word.kind == KIND_CHECK);
        if (in_word.kind == KIND_ACQUIRE) begin
          out_word_nxt.status = STAT_EMPTY;
        end else if ((in_word.kind == KIND_RELEASE) && stat.full) begin
          out_word_nxt.status = STAT_FULL;
        end else begin
          out_word_nxt.status = STAT_OK;
        end
      end
      FIN_POP:  out_word_nxt.granted = value;
      FIN_SCAN: out_word_nxt.in_use = !stat.hit;
      FIN_SUM:  out_word_nxt.slot_address = ADDR_W'(base_r) + ADDR_W'(prod_r);
      default:  out_word_nxt = out_word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.fin != FIN_NONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CAP_C) && (mark_r <= CAP_C))
    else $error("free count or low-water mark beyond capacity");
  a_full_release_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (in_word.kind == KIND_RELEASE) && stat.full) |=> $stable(count_r))
    else $error("release on a full stack changed the count");
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin == FIN_SCAN) |-> (stat.hit || stat.last))
    else $error("scan finished before a match or the last entry");
`endif

endmodule
`default_nettype wire

// ===== src/hfla_ctrl.sv =====
// Controller state machine that sequences the allocator datapath.
`default_nettype none
module hfla_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  hfla_pkg::kind_t       kind,
  input  hfla_pkg::dp_status_t  stat,
  output hfla_pkg::cmd_t        cmd,
  output logic                  busy
);
  import hfla_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (kind)
            KIND_ACQUIRE: state_nxt = stat.empty ? ST_IDLE : ST_POP;
            KIND_RELEASE: state_nxt = ST_IDLE;
            KIND_CHECK:   state_nxt = stat.empty ? ST_IDLE : ST_SCAN;
            KIND_ADDRESS: state_nxt = ST_SUM;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POP:  state_nxt = ST_IDLE;
      ST_SCAN: state_nxt = (stat.hit || stat.last) ? ST_IDLE : ST_SCAN;
      ST_SUM:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && ((kind == KIND_RELEASE) ||
                      (((kind == KIND_ACQUIRE) || (kind == KIND_CHECK)) && stat.empty))) begin
          cmd.fin = FIN_IMM;
        end
      end
      ST_POP:  cmd.fin = FIN_POP;
      ST_SCAN: begin
        if (stat.hit || stat.last) begin
          cmd.fin = FIN_SCAN;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_SUM:  cmd.fin = FIN_SUM;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef ASSERT_OFF
  a_single_cycle_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_POP) || (state_r == ST_SUM)) |=> (state_r == ST_IDLE))
    else $error("pop or address step did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== src/handle_free_list_allocator_unit.sv =====
// Top level of the handle free-list allocator.
`default_nettype none
// A word is taken when start is high and busy is low; its single result appears on
// out_word for one cycle with out_valid, and the receiver cannot hold it off. Release,
// acquire on an empty stack and check on an empty stack answer in the cycle after the word
// is taken; acquire and address pass through the pop or sum state before the result
// register answers; check scans the free stack one entry per cycle through the stack
// memory's single read port. Busy is low again in the cycle the result appears, so the
// next word can be taken then. Configuration writes take effect at once and must only be
// made while no word is in flight.
module handle_free_list_allocator_unit #(
  parameter int CAPACITY = hfla_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  hfla_pkg::in_t                     in_word,
  output logic                              out_valid,
  output hfla_pkg::out_t                    out_word,
  input  logic                              cfg_we,
  input  logic [hfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hfla_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hfla_pkg::*;

  cmd_t       cmd;
  dp_status_t stat;

  hfla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_word.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  hfla_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench of the handle free-list allocator unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hfla_pkg::*;

  class alloc_scoreboard;
    logic [HANDLE_W-1:0] free_stack [CAPACITY_DEF];
    int unsigned free_count;
    logic [BASE_W-1:0] base_address;
    logic [SLOT_W-1:0] slot_size;
    out_t expected_q [$];
    int errors;

    function new();
      for (int i = 0; i < CAPACITY_DEF; i++) begin
        free_stack[i] = HANDLE_W'(i);
      end
      free_count = CAPACITY_DEF;
      base_address = '0;
      slot_size = SLOT_SIZE_RST;
      errors = 0;
    endfunction

    function void set_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE_ADDRESS: base_address = data[BASE_W-1:0];
        CFG_SLOT_SIZE:    slot_size = data[SLOT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_free(logic [HANDLE_W-1:0] h);
      for (int i = 0; i < free_count; i++) begin
        if (free_stack[i] == h) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int held_handle();
      int first;
      int h;
      first = $urandom_range(CAPACITY_DEF - 1);
      for (int i = 0; i < CAPACITY_DEF; i++) begin
        h = (first + i) % CAPACITY_DEF;
        if (!is_free(HANDLE_W'(h))) return h;
      end
      return -1;
    endfunction

    function void note_word(in_t w);
      out_t exp;
      logic [PROD_W-1:0] prod;
      exp = '0;
      exp.status = STAT_OK;
      case (w.kind)
        KIND_ACQUIRE: begin
          if (free_count == 0) begin
            exp.status = STAT_EMPTY;
          end else begin
            free_count--;
            exp.granted = free_stack[free_count];
          end
        end
        KIND_RELEASE: begin
          if (free_count >= CAPACITY_DEF) begin
            exp.status = STAT_FULL;
          end else begin
            free_stack[free_count] = w.handle;
            free_count++;
          end
        end
        KIND_CHECK: begin
          exp.in_use = !is_free(w.handle);
        end
        KIND_ADDRESS: begin
          prod = PROD_W'(w.handle) * PROD_W'(slot_size);
          exp.slot_address = {1'b0, base_address} + ADDR_W'(prod);
        end
        default: ;
      endcase
      expected_q = {expected_q, exp};
    endfunction

    function void report(string what, logic [63:0] exp_val, logic [63:0] got_val);
      errors++;
      $display("ERROR %0t: %s expected %0h got %0h", $realtime, what, exp_val, got_val);
    endfunction

    function void check_word(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        report("word with nothing expected", '0, 64'(got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.granted !== exp.granted) report("granted", 64'(exp.granted), 64'(got.granted));
      if (got.in_use !== exp.in_use) report("in_use", 64'(exp.in_use), 64'(got.in_use));
      if (got.slot_address !== exp.slot_address) begin
        report("slot_address", 64'(exp.slot_address), 64'(got.slot_address));
      end
      if (got.status !== exp.status) report("status", 64'(exp.status), 64'(got.status));
    endfunction
  endclass

  typedef enum int {TRAFFIC_DRAIN, TRAFFIC_FILL, TRAFFIC_MIX} traffic_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * CAPACITY_DEF + 16;
  localparam int PHASES = 4;
  localparam int PHASE_WORDS = 75;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_word;
  logic out_valid;
  out_t out_word;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  alloc_scoreboard sb = new();
  bit idle_enabled;
  int cycle_count = 0;

  handle_free_list_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_word(out_word);
  end

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(input in_t w);
    if (idle_enabled && $urandom_range(99) < 7) pause_cycles($urandom_range(1, 4));
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
  endtask

  task automatic send_request(input kind_t k, input logic [HANDLE_W-1:0] h);
    in_t w;
    w.kind = k;
    w.handle = h;
    send_word(w);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(idx, data);
  endtask

  task automatic send_random(input traffic_t mode);
    in_t w;
    int r;
    int pick;
    int held;
    r = $urandom_range(99);
    pick = $urandom_range(2);
    case (mode)
      TRAFFIC_DRAIN: w.kind = (r < 70) ? KIND_ACQUIRE : kind_t'(1 + pick);
      TRAFFIC_FILL: begin
        if (r < 70) w.kind = KIND_RELEASE;
        else w.kind = (pick == 0) ? KIND_ACQUIRE : ((pick == 1) ? KIND_CHECK : KIND_ADDRESS);
      end
      default: w.kind = kind_t'($urandom_range(3));
    endcase
    w.handle = HANDLE_W'($urandom_range(CAPACITY_DEF - 1));
    held = sb.held_handle();
    if (held >= 0 && (w.kind == KIND_RELEASE || w.kind == KIND_CHECK)
        && $urandom_range(9) < 6) begin
      w.handle = HANDLE_W'(held);
    end
    send_word(w);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    int r;
    r = $urandom_range(5);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_slot();
    logic [SLOT_W-1:0] s;
    int r;
    r = $urandom_range(7);
    if (r == 0) s = 16'd1;
    else if (r == 1) s = 16'hFFFF;
    else if (r == 2) s = '0;
    else s = SLOT_W'($urandom_range(1, 16'hFFFF));
    return {16'($urandom()), s};
  endfunction

  initial begin
    int sent;
    int seg_len;
    int seg_no;
    traffic_t mode;
    start <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    idle_enabled = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_CHECK, 6'd63);
    send_request(KIND_CHECK, 6'd0);
    send_request(KIND_RELEASE, 6'd5);
    send_request(KIND_ADDRESS, 6'd0);
    send_request(KIND_ADDRESS, 6'd63);
    send_request(KIND_ACQUIRE, 6'd0);
    send_request(KIND_ACQUIRE, 6'd63);
    send_request(KIND_CHECK, 6'd63);
    send_request(KIND_RELEASE, 6'd63);
    send_request(KIND_RELEASE, 6'd63);
    send_request(KIND_RELEASE, 6'd0);
    send_request(KIND_CHECK, 6'd62);
    send_request(KIND_ACQUIRE, 6'd21);
    send_request(KIND_RELEASE, 6'd42);
    send_request(KIND_CHECK, 6'd42);

    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
    write_reg(CFG_SLOT_SIZE, 32'h0000_FFFF);
    send_request(KIND_ADDRESS, 6'd63);
    send_request(KIND_ADDRESS, 6'd0);
    send_request(KIND_ADDRESS, 6'd42);
    send_request(KIND_ADDRESS, 6'd21);

    write_reg(CFG_SLOT_SIZE, 32'hFFFF_0000);
    write_reg(CFG_BASE_ADDRESS, 32'h1234_5678);
    send_request(KIND_ADDRESS, 6'd63);
    write_reg(CFG_SLOT_SIZE, 32'h0000_0001);
    write_reg(CFG_BASE_ADDRESS, 32'h0000_0000);
    send_request(KIND_ADDRESS, 6'd63);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(CFG_BASE_ADDRESS, pick_base());
      write_reg(CFG_SLOT_SIZE, pick_slot());
      idle_enabled = (phase != 2);
      sent = 0;
      seg_no = 0;
      while (sent < PHASE_WORDS) begin
        if (phase == 0 && seg_no == 0) begin
          mode = TRAFFIC_DRAIN;
          seg_len = 70;
        end else if (phase == 0 && seg_no == 1) begin
          mode = TRAFFIC_FILL;
          seg_len = 70;
        end else begin
          mode = traffic_t'($urandom_range(2));
          seg_len = $urandom_range(4, 40);
        end
        for (int i = 0; i < seg_len; i++) send_random(mode);
        sent += seg_len;
        seg_no++;
        if ($urandom_range(4) == 0) wait_results();
      end
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hfla_pkg.sv
src/hfla_dp.sv
src/hfla_ctrl.sv
src/handle_free_list_allocator_unit.sv
verif/tb_top.sv
